// ===== hw/rtl/feq_pkg.sv =====
// Shared types and constants for the frame-ordered event queue.
// Holds the entry layout, the cell command bundle and the command/status codes.
// No dependencies; used by feq_cell and frame_ordered_event_queue.
`timescale 1ns / 1ps
`default_nettype none

package feq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int FRAME_W  = 24;
    localparam int ID_W     = 32;
    localparam int USER_W   = 32;
    localparam int OBJ_W    = 16;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int RCOUNT_W = 5;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    // Cell operations broadcast along the chain
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic signed [FRAME_W-1:0] frame;
        logic [ID_W-1:0]           id;
        logic [USER_W-1:0]         user;
        logic [OBJ_W-1:0]          obj;
    } entry_t;

    typedef struct packed {
        logic [1:0]                op;
        logic                      by_range;
        logic signed [FRAME_W-1:0] key_frame;
        logic signed [FRAME_W-1:0] key_to;
        logic [ID_W-1:0]           key_id;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/feq_cell.sv =====
// One storage cell of the sorted event chain.
// Holds one entry and shifts it toward either neighbor on a broadcast command.
// Depends on feq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module feq_cell #(
    parameter int QUEUE_DEPTH = feq_pkg::DEFAULT_DEPTH,
    parameter int INDEX       = 0
) (
    input  wire logic                             aclk,
    input  wire feq_pkg::cell_cmd_t               cmd,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    input  wire feq_pkg::entry_t                  bus_in,
    input  wire feq_pkg::entry_t                  prev_in,
    input  wire feq_pkg::entry_t                  next_in,
    input  wire logic                             flag_in,
    output logic                                  flag_out,
    output logic                                  first_hit,
    output feq_pkg::entry_t                       data_out
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

    feq_pkg::entry_t entry_reg;
    feq_pkg::entry_t entry_next;

    logic occupied;
    logic is_tail;
    logic at_or_after;
    logic in_range;
    logic hit;

    assign occupied    = (IDX < count);
    assign is_tail     = (IDX_NEXT == count);
    assign at_or_after = !occupied || ($signed(cmd.key_frame) <= $signed(entry_reg.frame));
    assign in_range    = ($signed(cmd.key_frame) <= $signed(entry_reg.frame))
                         && ($signed(entry_reg.frame) < $signed(cmd.key_to));
    assign hit         = occupied && (cmd.by_range ? in_range : (entry_reg.id == cmd.key_id));

    always_comb begin
        entry_next = entry_reg;
        flag_out   = 1'b0;
        first_hit  = 1'b0;
        unique case (cmd.op)
            feq_pkg::CELL_INSERT: begin
                // flag marks "new entry lands here or earlier"
                flag_out = flag_in | at_or_after;
                if (flag_out && !flag_in) begin
                    entry_next = bus_in;
                end else if (flag_out) begin
                    entry_next = prev_in;
                end
            end
            feq_pkg::CELL_DELETE: begin
                // flag marks "first hit is here or earlier"
                flag_out  = flag_in | hit;
                first_hit = hit & ~flag_in;
                if (flag_out) begin
                    entry_next = next_in;
                end
            end
            feq_pkg::CELL_ROTATE: begin
                if (is_tail) begin
                    entry_next = bus_in;
                end else if (occupied) begin
                    entry_next = next_in;
                end
            end
            feq_pkg::CELL_HOLD: begin
                entry_next = entry_reg;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign data_out = entry_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/frame_ordered_event_queue.sv =====
// Frame-ordered event queue: sequencer, output register and the chain of cells.
// Depends on feq_pkg and feq_cell.
//
// Usage:
//   Input channel s_*: one command item per handshake (add, move, remove by id,
//   remove frame range, list). Result channel m_*: one item per result, with
//   m_last high on the final item caused by a command.
//   Entries live in a row of QUEUE_DEPTH cells kept sorted by ascending signed
//   frame; every cell that moves shifts to a neighbor in the same cycle, so one
//   insert or one delete is a single pass over the chain.
// Steps (from acceptance until the result is loaded, receiver ready):
//   add, remove by id, unused kinds: the result is loaded from the execute step.
//   move: a delete pass, then an insert pass; only the delete pass when the id is missing.
//   range remove: one delete pass per entry removed, then the result.
//   list: the chain rotates once per entry and the first 16 entries go out,
//   one per cycle while the receiver is ready, in order.
// s_ready is high only while the sequencer is idle; a finished result waits in
// the output register and does not block the next command.
// Stall: a stalled receiver freezes the sequencer only on cycles that may
// load a result; queue contents are never lost.
// Reset: aresetn (synchronous, active low) empties the queue, drops any
// pending result and returns the sequencer to idle. Entry storage is not
// cleared; only occupied cells are ever read.
`timescale 1ns / 1ps
`default_nettype none

module frame_ordered_event_queue #(
    parameter int QUEUE_DEPTH = feq_pkg::DEFAULT_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [feq_pkg::KIND_W-1:0]     s_kind,
    input  wire logic signed [feq_pkg::FRAME_W-1:0] s_frame,
    input  wire logic signed [feq_pkg::FRAME_W-1:0] s_range_to,
    input  wire logic signed [feq_pkg::ID_W-1:0]    s_event_id,
    input  wire logic signed [feq_pkg::USER_W-1:0]  s_user_word,
    input  wire logic [feq_pkg::OBJ_W-1:0]      s_object_handle,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [feq_pkg::STATUS_W-1:0]        m_status,
    output logic [feq_pkg::RCOUNT_W-1:0]        m_removed_count,
    output logic                                m_entry_valid,
    output logic signed [feq_pkg::FRAME_W-1:0]  m_entry_frame,
    output logic signed [feq_pkg::ID_W-1:0]     m_entry_id,
    output logic signed [feq_pkg::USER_W-1:0]   m_entry_user,
    output logic [feq_pkg::OBJ_W-1:0]           m_entry_object,
    output logic                                m_last
);

    localparam int CW         = $clog2(QUEUE_DEPTH + 1);
    localparam int LIST_MAX_N = (QUEUE_DEPTH < feq_pkg::MAX_RESULTS) ?
                                QUEUE_DEPTH : feq_pkg::MAX_RESULTS;
    localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] LIST_CAP_C = CW'(LIST_MAX_N);

    localparam logic [1:0] FSM_IDLE     = 2'd0;
    localparam logic [1:0] FSM_EXEC     = 2'd1;
    localparam logic [1:0] FSM_MOVE_INS = 2'd2;
    localparam logic [1:0] FSM_LIST     = 2'd3;

    // Sequencer and occupancy
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg,  step_next;
    logic [CW-1:0] nrem_reg,  nrem_next;
    logic [feq_pkg::OBJ_W-1:0] keep_obj_reg, keep_obj_next;

    // Captured command
    logic [feq_pkg::KIND_W-1:0]         kind_reg;
    logic signed [feq_pkg::FRAME_W-1:0] frame_reg;
    logic signed [feq_pkg::FRAME_W-1:0] to_reg;
    logic [feq_pkg::ID_W-1:0]           id_reg;
    logic [feq_pkg::USER_W-1:0]         user_reg;
    logic [feq_pkg::OBJ_W-1:0]          obj_reg;

    // Output register
    logic                              m_valid_reg;
    logic [feq_pkg::STATUS_W-1:0]      status_reg;
    logic [feq_pkg::RCOUNT_W-1:0]      rcount_reg;
    logic                              evalid_reg;
    feq_pkg::entry_t                   entry_reg;
    logic                              last_reg;

    // Result being loaded this cycle
    logic                              out_free;
    logic                              out_load;
    logic [feq_pkg::STATUS_W-1:0]      res_status;
    logic [feq_pkg::RCOUNT_W-1:0]      res_rcount;
    logic                              res_evalid;
    feq_pkg::entry_t                   res_entry;
    logic                              res_last;

    // Chain signals
    feq_pkg::cell_cmd_t cell_cmd;
    feq_pkg::entry_t    bus;
    feq_pkg::entry_t    cell_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   flag;
    logic [QUEUE_DEPTH-1:0] first_hit;
    logic                   any_hit;
    logic [feq_pkg::OBJ_W-1:0] hit_obj;

    logic          s_fire;
    logic [CW-1:0] step_plus;
    logic [CW-1:0] list_n;
    logic          list_emit;

    assign s_ready   = (state_reg == FSM_IDLE);
    assign s_fire    = s_valid & s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign step_plus = step_reg + 1'b1;
    assign list_n    = (count_reg > LIST_CAP_C) ? LIST_CAP_C : count_reg;
    assign list_emit = (step_reg < LIST_CAP_C);
    assign any_hit   = flag[QUEUE_DEPTH];

    // ---------------------------------------------------------------
    // Cell chain: flags ripple from cell 0 toward the tail
    // ---------------------------------------------------------------
    assign flag[0] = 1'b0;

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            feq_pkg::entry_t prev_d;
            feq_pkg::entry_t next_d;
            if (i == 0) begin : g_head
                assign prev_d = bus;
            end else begin : g_mid_prev
                assign prev_d = cell_data[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign next_d = cell_data[i];
            end else begin : g_mid_next
                assign next_d = cell_data[i+1];
            end
            feq_cell #(
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .INDEX       (i)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (cell_cmd),
                .count     (count_reg),
                .bus_in    (bus),
                .prev_in   (prev_d),
                .next_in   (next_d),
                .flag_in   (flag[i]),
                .flag_out  (flag[i+1]),
                .first_hit (first_hit[i]),
                .data_out  (cell_data[i])
            );
        end
    endgenerate

    // Pick the object handle of the first matching cell (one-hot select)
    always_comb begin
        hit_obj = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hit_obj = hit_obj | (cell_data[i].obj & {feq_pkg::OBJ_W{first_hit[i]}});
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        nrem_next     = nrem_reg;
        keep_obj_next = keep_obj_reg;

        cell_cmd.op        = feq_pkg::CELL_HOLD;
        cell_cmd.by_range  = 1'b0;
        cell_cmd.key_frame = frame_reg;
        cell_cmd.key_to    = to_reg;
        cell_cmd.key_id    = id_reg;

        bus.frame = frame_reg;
        bus.id    = id_reg;
        bus.user  = user_reg;
        bus.obj   = obj_reg;

        out_load   = 1'b0;
        res_status = feq_pkg::STAT_DONE;
        res_rcount = '0;
        res_evalid = 1'b0;
        res_entry  = '0;
        res_last   = 1'b1;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    state_next = FSM_EXEC;
                    nrem_next  = '0;
                    step_next  = '0;
                end
            end

            FSM_EXEC: begin
                case (kind_reg)
                    feq_pkg::KIND_ADD: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = FSM_IDLE;
                            if (count_reg == DEPTH_C) begin
                                res_status = feq_pkg::STAT_FULL;
                            end else begin
                                cell_cmd.op = feq_pkg::CELL_INSERT;
                                count_next  = count_reg + 1'b1;
                                res_rcount  = feq_pkg::RCOUNT_W'(1);
                            end
                        end
                    end
                    feq_pkg::KIND_MOVE: begin
                        if (out_free) begin
                            cell_cmd.op = feq_pkg::CELL_DELETE;
                            if (any_hit) begin
                                // take it out now, reinsert on the next cycle
                                count_next    = count_reg - 1'b1;
                                keep_obj_next = hit_obj;
                                state_next    = FSM_MOVE_INS;
                            end else begin
                                out_load   = 1'b1;
                                res_status = feq_pkg::STAT_NOT_FOUND;
                                state_next = FSM_IDLE;
                            end
                        end
                    end
                    feq_pkg::KIND_REMOVE: begin
                        if (out_free) begin
                            cell_cmd.op = feq_pkg::CELL_DELETE;
                            out_load    = 1'b1;
                            state_next  = FSM_IDLE;
                            if (any_hit) begin
                                count_next = count_reg - 1'b1;
                                res_rcount = feq_pkg::RCOUNT_W'(1);
                            end else begin
                                res_status = feq_pkg::STAT_NOT_FOUND;
                            end
                        end
                    end
                    feq_pkg::KIND_RANGE: begin
                        // drop one in-range entry per cycle until none is left
                        cell_cmd.op       = feq_pkg::CELL_DELETE;
                        cell_cmd.by_range = 1'b1;
                        if (any_hit) begin
                            count_next = count_reg - 1'b1;
                            nrem_next  = nrem_reg + 1'b1;
                        end else if (out_free) begin
                            out_load   = 1'b1;
                            res_rcount = feq_pkg::RCOUNT_W'(nrem_reg);
                            state_next = FSM_IDLE;
                        end
                    end
                    feq_pkg::KIND_LIST: begin
                        if (count_reg == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                state_next = FSM_IDLE;
                            end
                        end else begin
                            state_next = FSM_LIST;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = FSM_IDLE;
                        end
                    end
                endcase
            end

            FSM_MOVE_INS: begin
                if (out_free) begin
                    cell_cmd.op = feq_pkg::CELL_INSERT;
                    bus.user    = '0;
                    bus.obj     = keep_obj_reg;
                    count_next  = count_reg + 1'b1;
                    out_load    = 1'b1;
                    res_rcount  = feq_pkg::RCOUNT_W'(1);
                    state_next  = FSM_IDLE;
                end
            end

            FSM_LIST: begin
                // rotate the head entry to the tail; emit it while under the cap
                bus = cell_data[0];
                if (!list_emit || out_free) begin
                    cell_cmd.op = feq_pkg::CELL_ROTATE;
                    step_next   = step_plus;
                    if (step_plus == count_reg) begin
                        state_next = FSM_IDLE;
                    end
                    if (list_emit) begin
                        out_load   = 1'b1;
                        res_evalid = 1'b1;
                        res_entry  = cell_data[0];
                        res_last   = (step_plus == list_n);
                    end
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            nrem_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            nrem_reg  <= nrem_next;
        end
    end

    // Command capture and saved handle: payload only
    always_ff @(posedge aclk) begin
        keep_obj_reg <= keep_obj_next;
        if (s_fire) begin
            kind_reg  <= s_kind;
            frame_reg <= s_frame;
            to_reg    <= s_range_to;
            id_reg    <= s_event_id;
            user_reg  <= s_user_word;
            obj_reg   <= s_object_handle;
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until the receiver takes it
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= res_status;
            rcount_reg <= res_rcount;
            evalid_reg <= res_evalid;
            entry_reg  <= res_entry;
            last_reg   <= res_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_removed_count = rcount_reg;
    assign m_entry_valid   = evalid_reg;
    assign m_entry_frame   = entry_reg.frame;
    assign m_entry_id      = entry_reg.id;
    assign m_entry_user    = entry_reg.user;
    assign m_entry_object  = entry_reg.obj;
    assign m_last          = last_reg;

`ifndef SYNTH
    // Occupancy never passes the number of cells
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("occupancy above queue depth");

    // A new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overrun");

    // Listing only runs on a non-empty queue and leaves occupancy unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_LIST) |-> (count_reg != '0))
        else $error("list pass on empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_LIST) |=> (count_reg == $past(count_reg)))
        else $error("occupancy changed during list");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_frame_ordered_event_queue.sv =====
// Self-checking testbench for frame_ordered_event_queue: a scoreboard class mirrors the
// sorted store and predicts every result item; directed and phased random commands.
// Depends on feq_pkg and the frame_ordered_event_queue RTL.
`timescale 1ns / 1ps

module tb_frame_ordered_event_queue;

    localparam int DEPTH = feq_pkg::DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES = 40;

    // Command kinds the block does not use; they must change nothing.
    localparam logic [feq_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [feq_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam logic signed [feq_pkg::FRAME_W-1:0] FRAME_MIN =
        {1'b1, {(feq_pkg::FRAME_W-1){1'b0}}};
    localparam logic signed [feq_pkg::FRAME_W-1:0] FRAME_MAX =
        {1'b0, {(feq_pkg::FRAME_W-1){1'b1}}};

    typedef struct packed {
        logic [feq_pkg::KIND_W-1:0]         kind;
        logic signed [feq_pkg::FRAME_W-1:0] frame;
        logic signed [feq_pkg::FRAME_W-1:0] range_to;
        logic [feq_pkg::ID_W-1:0]           event_id;
        logic [feq_pkg::USER_W-1:0]         user_word;
        logic [feq_pkg::OBJ_W-1:0]          object_handle;
    } command_t;

    typedef struct packed {
        logic [feq_pkg::STATUS_W-1:0] status;
        logic [feq_pkg::RCOUNT_W-1:0] removed_count;
        logic                         entry_valid;
        logic [feq_pkg::FRAME_W-1:0]  entry_frame;
        logic [feq_pkg::ID_W-1:0]     entry_id;
        logic [feq_pkg::USER_W-1:0]   entry_user;
        logic [feq_pkg::OBJ_W-1:0]    entry_object;
        logic                         last;
    } queue_result_t;

    // Random stimulus runs in phases that steer the store's fill level.
    typedef enum logic [1:0] {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_e;

    // ------------------------------------------------------------------
    // Scoreboard: a sorted copy of the store plus the queue of results
    // that accepted commands still owe.
    // ------------------------------------------------------------------
    class event_queue_scoreboard;
        feq_pkg::entry_t slots [DEPTH];
        int              occupied;
        queue_result_t   awaited [$];
        int              errors;
        int              checked;
        int              full_drops;
        int              longest_list;

        function new();
            occupied     = 0;
            errors       = 0;
            checked      = 0;
            full_drops   = 0;
            longest_list = 0;
        endfunction

        function int find_event(logic [feq_pkg::ID_W-1:0] id);
            for (int i = 0; i < occupied; i++)
                if (slots[i].id == id) return i;
            return -1;
        endfunction

        function void take_out(int pos);
            for (int i = pos; i + 1 < occupied; i++)
                slots[i] = slots[i + 1];
            occupied--;
        endfunction

        // Insert ahead of the first entry whose frame is equal or later.
        function void place(feq_pkg::entry_t e);
            int pos;
            pos = 0;
            while (pos < occupied && !($signed(e.frame) <= $signed(slots[pos].frame)))
                pos++;
            for (int i = occupied; i > pos; i--)
                slots[i] = slots[i - 1];
            slots[pos] = e;
            occupied++;
        endfunction

        function void owe_status(logic [feq_pkg::STATUS_W-1:0] status, int count);
            queue_result_t r;
            r               = '0;
            r.status        = status;
            r.removed_count = feq_pkg::RCOUNT_W'(count);
            r.last          = 1'b1;
            awaited.push_back(r);
        endfunction

        // Apply one accepted command and queue the results it causes.
        function void note_command(command_t c);
            feq_pkg::entry_t e;
            queue_result_t   r;
            int              pos;
            int              n;
            case (c.kind) inside
                feq_pkg::KIND_ADD: begin
                    if (occupied >= DEPTH) begin
                        full_drops++;
                        owe_status(feq_pkg::STAT_FULL, 0);
                    end else begin
                        e.frame = c.frame;
                        e.id    = c.event_id;
                        e.user  = c.user_word;
                        e.obj   = c.object_handle;
                        place(e);
                        owe_status(feq_pkg::STAT_DONE, 1);
                    end
                end
                feq_pkg::KIND_MOVE, feq_pkg::KIND_REMOVE: begin
                    pos = find_event(c.event_id);
                    if (pos < 0) begin
                        owe_status(feq_pkg::STAT_NOT_FOUND, 0);
                    end else begin
                        e = slots[pos];
                        take_out(pos);
                        if (c.kind == feq_pkg::KIND_MOVE) begin
                            // keep id and object, clear the user word
                            e.frame = c.frame;
                            e.user  = '0;
                            place(e);
                        end
                        owe_status(feq_pkg::STAT_DONE, 1);
                    end
                end
                feq_pkg::KIND_RANGE: begin
                    n   = 0;
                    pos = 0;
                    while (pos < occupied) begin
                        if ($signed(slots[pos].frame) < $signed(c.range_to) &&
                            $signed(c.frame) <= $signed(slots[pos].frame)) begin
                            take_out(pos);
                            n++;
                        end else begin
                            pos++;
                        end
                    end
                    owe_status(feq_pkg::STAT_DONE, n);
                end
                feq_pkg::KIND_LIST: begin
                    if (occupied == 0) begin
                        owe_status(feq_pkg::STAT_DONE, 0);
                    end else begin
                        n = (occupied < feq_pkg::MAX_RESULTS) ? occupied
                                                              : feq_pkg::MAX_RESULTS;
                        if (n > longest_list) longest_list = n;
                        for (int i = 0; i < n; i++) begin
                            r              = '0;
                            r.entry_valid  = 1'b1;
                            r.entry_frame  = slots[i].frame;
                            r.entry_id     = slots[i].id;
                            r.entry_user   = slots[i].user;
                            r.entry_object = slots[i].obj;
                            r.last         = (i + 1 == n);
                            awaited.push_back(r);
                        end
                    end
                end
                default: owe_status(feq_pkg::STAT_DONE, 0);
            endcase
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest outstanding one.
        function void check_result(queue_result_t got);
            queue_result_t want;
            checked++;
            if (awaited.size() == 0) begin
                $error("result item with nothing outstanding (status %0d, last %0d)",
                       got.status, got.last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            match_field("status",        32'(want.status),        32'(got.status));
            match_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
            match_field("entry_valid",   32'(want.entry_valid),   32'(got.entry_valid));
            match_field("entry_frame",   32'(want.entry_frame),   32'(got.entry_frame));
            match_field("entry_id",      want.entry_id,           got.entry_id);
            match_field("entry_user",    want.entry_user,         got.entry_user);
            match_field("entry_object",  32'(want.entry_object),  32'(got.entry_object));
            match_field("last",          32'(want.last),          32'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic                               s_valid;
    logic                               s_ready;
    logic [feq_pkg::KIND_W-1:0]         s_kind;
    logic signed [feq_pkg::FRAME_W-1:0] s_frame;
    logic signed [feq_pkg::FRAME_W-1:0] s_range_to;
    logic signed [feq_pkg::ID_W-1:0]    s_event_id;
    logic signed [feq_pkg::USER_W-1:0]  s_user_word;
    logic [feq_pkg::OBJ_W-1:0]          s_object_handle;

    logic                               m_valid;
    logic                               m_ready;
    logic [feq_pkg::STATUS_W-1:0]       m_status;
    logic [feq_pkg::RCOUNT_W-1:0]       m_removed_count;
    logic                               m_entry_valid;
    logic signed [feq_pkg::FRAME_W-1:0] m_entry_frame;
    logic signed [feq_pkg::ID_W-1:0]    m_entry_id;
    logic signed [feq_pkg::USER_W-1:0]  m_entry_user;
    logic [feq_pkg::OBJ_W-1:0]          m_entry_object;
    logic                               m_last;

    event_queue_scoreboard sb;
    bit                    no_idle;       // when set, neither side inserts gaps
    int                    kind_seen [8];

    always #4 aclk = ~aclk;

    frame_ordered_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_frame        (s_frame),
        .s_range_to     (s_range_to),
        .s_event_id     (s_event_id),
        .s_user_word    (s_user_word),
        .s_object_handle(s_object_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_removed_count(m_removed_count),
        .m_entry_valid  (m_entry_valid),
        .m_entry_frame  (m_entry_frame),
        .m_entry_id     (m_entry_id),
        .m_entry_user   (m_entry_user),
        .m_entry_object (m_entry_object),
        .m_last         (m_last)
    );

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic command_t command_of(logic [feq_pkg::KIND_W-1:0] kind,
                                            logic signed [feq_pkg::FRAME_W-1:0] frame,
                                            logic signed [feq_pkg::FRAME_W-1:0] range_to,
                                            logic [feq_pkg::ID_W-1:0] id,
                                            logic [feq_pkg::USER_W-1:0] user,
                                            logic [feq_pkg::OBJ_W-1:0] obj);
        command_t c;
        c.kind          = kind;
        c.frame         = frame;
        c.range_to      = range_to;
        c.event_id      = id;
        c.user_word     = user;
        c.object_handle = obj;
        return c;
    endfunction

    // Mostly a narrow window so frames tie and ranges hit; sometimes extremes
    // or a full-width value so every bit toggles.
    function automatic logic signed [feq_pkg::FRAME_W-1:0] pick_frame();
        logic signed [feq_pkg::FRAME_W-1:0] f;
        case ($urandom_range(0, 9))
            6:       f = FRAME_MIN;
            7:       f = FRAME_MAX;
            8, 9:    f = feq_pkg::FRAME_W'($urandom);
            default: begin
                f = feq_pkg::FRAME_W'($urandom_range(0, 48));
                f = f - feq_pkg::FRAME_W'(24);
            end
        endcase
        return f;
    endfunction

    // Small id pool so moves and removes find their target; edge ids and
    // full-width values now and then.
    function automatic logic [feq_pkg::ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            12:               return 32'hFFFF_FFFF;
            13:               return 32'h8000_0000;
            14:               return 32'h7FFF_FFFF;
            15, 16, 17, 18, 19: return $urandom;
            default:          return feq_pkg::ID_W'(r);
        endcase
    endfunction

    // Present one item after a random gap and hold it until the handshake.
    task automatic send_command(input command_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= c.kind;
        s_frame         <= c.frame;
        s_range_to      <= c.range_to;
        s_event_id      <= c.event_id;
        s_user_word     <= c.user_word;
        s_object_handle <= c.object_handle;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(c);
        kind_seen[c.kind]++;
    endtask

    // Accept result items with random stalls and hand each to the scoreboard.
    // Outputs are read right at the edge, so they hold their pre-edge values.
    task automatic drain_results();
        int            stall;
        queue_result_t got;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.status        = m_status;
            got.removed_count = m_removed_count;
            got.entry_valid   = m_entry_valid;
            got.entry_frame   = m_entry_frame;
            got.entry_id      = m_entry_id;
            got.entry_user    = m_entry_user;
            got.entry_object  = m_entry_object;
            got.last          = m_last;
            sb.check_result(got);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        phase_e                             phase;
        command_t                           c;
        int                                 roll;
        int                                 t_add, t_move, t_remove, t_range, t_list;
        int                                 total;
        int                                 spare;
        logic signed [feq_pkg::FRAME_W-1:0] from;

        sb      = new();
        no_idle = 1'b0;
        foreach (kind_seen[k]) kind_seen[k] = 0;

        // Hold every input at a known value through reset.
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_kind          <= feq_pkg::KIND_ADD;
        s_frame         <= '0;
        s_range_to      <= '0;
        s_event_id      <= '0;
        s_user_word     <= '0;
        s_object_handle <= '0;
        m_ready         <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            drain_results();
        join_none

        // Directed: empty-store cases, unused kinds, frame and word extremes,
        // ties, hits and misses for move/remove, inverted, empty and full ranges.
        send_command(command_of(feq_pkg::KIND_LIST,   '0, '0, '0, '0, '0));
        send_command(command_of(feq_pkg::KIND_REMOVE, '0, '0, 32'd7, '0, '0));
        send_command(command_of(feq_pkg::KIND_MOVE,   '0, '0, 32'd7, '0, '0));
        send_command(command_of(feq_pkg::KIND_RANGE,  FRAME_MIN, FRAME_MAX, '0, '0, '0));
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send_command(command_of(feq_pkg::KIND_W'(k), FRAME_MAX, FRAME_MIN,
                                    32'd1, 32'd1, 16'd1));
        send_command(command_of(feq_pkg::KIND_ADD, FRAME_MAX, '0, 32'h7FFF_FFFF,
                                32'h8000_0000, 16'hFFFF));
        send_command(command_of(feq_pkg::KIND_ADD, FRAME_MIN, '0, 32'h8000_0000,
                                32'h7FFF_FFFF, 16'h0000));
        send_command(command_of(feq_pkg::KIND_ADD, '0, '0, 32'd1, 32'hFFFF_FFFF, 16'h00A5));
        send_command(command_of(feq_pkg::KIND_ADD, '0, '0, 32'd2, 32'd0, 16'h5A00));
        send_command(command_of(feq_pkg::KIND_ADD, 24'sd256, '0, 32'd1, 32'd42, 16'd3));
        send_command(command_of(feq_pkg::KIND_LIST, '0, '0, '0, '0, '0));
        send_command(command_of(feq_pkg::KIND_MOVE, FRAME_MAX, '0, 32'd1, 32'd99, 16'd9));
        send_command(command_of(feq_pkg::KIND_REMOVE, '0, '0, 32'h8000_0000, '0, '0));
        send_command(command_of(feq_pkg::KIND_RANGE, 24'sd10, -24'sd10, '0, '0, '0));
        send_command(command_of(feq_pkg::KIND_RANGE, '0, '0, '0, '0, '0));
        send_command(command_of(feq_pkg::KIND_LIST, '0, '0, '0, '0, '0));
        send_command(command_of(feq_pkg::KIND_RANGE, FRAME_MIN, FRAME_MAX, '0, '0, '0));
        send_command(command_of(feq_pkg::KIND_LIST, '0, '0, '0, '0, '0));

        // Random: phases of 30 items, each picking at random between filling the
        // store (so adds hit full and lists run to 16), draining it, and a mix.
        phase = PHASE_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                phase   = phase_e'($urandom_range(0, 2));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            case (phase)
                PHASE_FILL:  begin
                    t_add = 70; t_move = 78; t_remove = 84; t_range = 88; t_list = 97;
                end
                PHASE_DRAIN: begin
                    t_add = 20; t_move = 35; t_remove = 60; t_range = 78; t_list = 96;
                end
                default:     begin
                    t_add = 40; t_move = 55; t_remove = 67; t_range = 77; t_list = 95;
                end
            endcase
            roll = $urandom_range(0, 99);

            c.frame         = pick_frame();
            c.range_to      = pick_frame();
            c.event_id      = pick_id();
            c.user_word     = $urandom;
            c.object_handle = ($urandom_range(0, 4) == 0) ? '0 : feq_pkg::OBJ_W'($urandom);
            if      (roll < t_add)    c.kind = feq_pkg::KIND_ADD;
            else if (roll < t_move)   c.kind = feq_pkg::KIND_MOVE;
            else if (roll < t_remove) c.kind = feq_pkg::KIND_REMOVE;
            else if (roll < t_range)  c.kind = feq_pkg::KIND_RANGE;
            else if (roll < t_list)   c.kind = feq_pkg::KIND_LIST;
            else c.kind = feq_pkg::KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));

            // Half the ranges are a short window starting at a likely frame.
            if (c.kind == feq_pkg::KIND_RANGE && $urandom_range(0, 1) == 0) begin
                from       = c.frame;
                c.range_to = from + feq_pkg::FRAME_W'($urandom_range(0, 40));
            end
            send_command(c);
        end
        s_valid <= 1'b0;

        // Drain what is still owed, then give the block time to show strays.
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        total = 0;
        foreach (kind_seen[k]) total += kind_seen[k];
        spare = 0;
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) spare += kind_seen[k];

        $display("Covered %0d commands: add %0d, move %0d, remove %0d, range %0d, list %0d, spare %0d",
                 total, kind_seen[feq_pkg::KIND_ADD], kind_seen[feq_pkg::KIND_MOVE],
                 kind_seen[feq_pkg::KIND_REMOVE], kind_seen[feq_pkg::KIND_RANGE],
                 kind_seen[feq_pkg::KIND_LIST], spare);
        $display("Checked %0d result items; %0d adds dropped on a full store; longest list %0d",
                 sb.checked, sb.full_drops, sb.longest_list);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (gaps, 16-item lists, full stalls).
    initial begin
        #5ms;
        $display("timeout: %0d result items still outstanding", sb.awaited.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
